[rtl/rtuigfr_pkg.sv]
// Package for the RTU idle-gap frame receiver.
// Holds the request and result types, register indexes and fixed constants.
// No dependencies.
package rtuigfr_pkg;

    // Request kinds on the input channel.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic        CFG_IDLE_LIMIT = 1'b0;
    localparam logic        CFG_RX_ENABLE  = 1'b1;
    localparam int unsigned CFG_DATA_W     = 16;

    // Idle counter width and its disarmed value.
    localparam int unsigned IDLE_W        = 16;
    localparam logic [15:0] IDLE_DISARMED = 16'hFFFF;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd2;

    // One input request.
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    // One result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       frame_end;
        logic       last;
    } t_out;

endpackage

[rtl/rtu_idle_gap_frame_receiver.sv]
// Top level of the RTU idle-gap frame receiver: frame buffer memory and control.
// Depends on rtuigfr_pkg.
//
// Modbus RTU receive framer. Each request is a received byte or a periodic tick.
// A byte is stored in the frame buffer when rx_enable is set; when the buffer
// holds BUFFER_BYTES bytes it is read out as a chunk run (frame_end = 0). The
// first tick after a byte starts the idle count; the tick that finds the count
// at idle_limit ends the frame, and the buffered bytes are read out as an
// end-of-frame run, or one empty frame-end result is given. The frame buffer is
// a single-port memory with a registered read, so each byte of a run takes a
// read and then a load of the output register; an empty frame end skips the
// read. No new request is taken while a run is being read out, and a stalled
// output holds the run. There is no clearing pass after reset.
module rtu_idle_gap_frame_receiver #(
    parameter int unsigned BUFFER_BYTES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [rtuigfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtuigfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  rtuigfr_pkg::t_in                       i_in,
    // Result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output rtuigfr_pkg::t_out                      o_out
);
    import rtuigfr_pkg::*;

    localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [7:0]        r_mem [BUFFER_BYTES];
    logic [7:0]        r_rd_data;

    logic [1:0]        r_state,     n_state;
    logic [AW-1:0]     r_fill,      n_fill;
    logic [IDLE_W-1:0] r_idle,      n_idle;
    logic              r_seen,      n_seen;
    logic [AW-1:0]     r_rd_ptr,    n_rd_ptr;
    logic [AW-1:0]     r_last_ptr,  n_last_ptr;
    logic              r_frame_end, n_frame_end;
    logic              r_empty,     n_empty;
    logic [IDLE_W-1:0] r_limit;
    logic              r_rx_en;
    t_out              r_out;
    logic              r_out_valid;

    logic in_acc;
    logic out_free;
    logic mem_we;
    logic rd_en;
    logic out_load;
    logic out_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign mem_we      = in_acc && (i_in.req_type == REQ_BYTE) && r_rx_en;
    assign rd_en       = (r_state == ST_READ);
    assign out_load    = (r_state == ST_LOAD) && out_free;
    assign out_last    = r_empty || (r_rd_ptr == r_last_ptr);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= IDLE_LIMIT_RST;
            r_rx_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDLE_LIMIT: r_limit <= i_cfg_data[IDLE_W-1:0];
                CFG_RX_ENABLE:  r_rx_en <= i_cfg_data[0];
            endcase
        end
    end

    // Frame buffer: one write or one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= i_in.rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Request handling and readout sequencing.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idle      = r_idle;
        n_seen      = r_seen;
        n_rd_ptr    = r_rd_ptr;
        n_last_ptr  = r_last_ptr;
        n_frame_end = r_frame_end;
        n_empty     = r_empty;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.req_type == REQ_BYTE) begin
                        n_seen = 1'b1;
                        if (r_rx_en) begin
                            if (r_fill == LAST_IDX) begin
                                // Buffer full: read it out as a chunk.
                                n_state     = ST_READ;
                                n_rd_ptr    = '0;
                                n_last_ptr  = LAST_IDX;
                                n_frame_end = 1'b0;
                                n_empty     = 1'b0;
                                n_fill      = '0;
                            end else begin
                                n_fill = r_fill + AW'(1);
                            end
                        end
                    end else if (r_seen) begin
                        n_seen = 1'b0;
                        n_idle = '0;
                    end else if (r_idle < r_limit) begin
                        n_idle = r_idle + IDLE_W'(1);
                    end else if (r_idle == r_limit) begin
                        // Idle gap reached: end the frame and disarm.
                        n_idle      = IDLE_DISARMED;
                        n_frame_end = 1'b1;
                        if (r_fill == '0) begin
                            n_empty = 1'b1;
                            n_state = ST_LOAD;
                        end else begin
                            n_empty    = 1'b0;
                            n_rd_ptr   = '0;
                            n_last_ptr = r_fill - AW'(1);
                            n_fill     = '0;
                            n_state    = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_ptr = r_rd_ptr + AW'(1);
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idle      <= IDLE_DISARMED;
            r_seen      <= 1'b0;
            r_rd_ptr    <= '0;
            r_last_ptr  <= '0;
            r_frame_end <= 1'b0;
            r_empty     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idle      <= n_idle;
            r_seen      <= n_seen;
            r_rd_ptr    <= n_rd_ptr;
            r_last_ptr  <= n_last_ptr;
            r_frame_end <= n_frame_end;
            r_empty     <= n_empty;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_byte  <= r_empty ? 8'd0 : r_rd_data;
            r_out.has_data  <= !r_empty;
            r_out.frame_end <= r_frame_end;
            r_out.last      <= out_last;
        end
    end

    // The fill level always stays below the buffer size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (32'(r_fill) < BUFFER_BYTES))
        else $error("fill level out of range");

    // A readout never runs past its last entry.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_rd_ptr <= r_last_ptr))
        else $error("read pointer beyond last entry");

    // A stored byte that fills the buffer starts a chunk readout.
    a_full_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_fill == LAST_IDX)) |=> (r_state == ST_READ) && (r_fill == '0))
        else $error("full buffer not read out");

    // An idle gap disarms the counter.
    a_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.req_type == REQ_TICK) && !r_seen && (r_idle == r_limit))
        |=> (r_idle == IDLE_DISARMED) && r_frame_end)
        else $error("idle counter not disarmed at frame end");

    // The output register is loaded only when it is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("pending result overwritten");

endmodule

[verif/rtu_idle_gap_frame_receiver_tb.sv]
// Testbench for the RTU idle-gap frame receiver: directed, random and backpressure tests.
// It predicts every result from its own model of the framer and checks it field by field.
// Depends on rtuigfr_pkg and rtu_idle_gap_frame_receiver.
`timescale 1ns / 1ps

module rtu_idle_gap_frame_receiver_tb;
    import rtuigfr_pkg::*;

    localparam int unsigned BUFFER_BYTES = 64;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out;

    // Framer model state and its copy of the registers.
    logic [7:0]  frame_bytes [BUFFER_BYTES];
    int          bytes_held;
    logic [15:0] quiet_ticks;
    bit          heard_byte;
    logic [15:0] gap_limit;
    bit          store_enable;

    // Results still owed by the block, oldest first.
    t_out        pending_results[$];

    int          fail_count;
    int          requests_sent;
    bit          sender_gaps;
    bit          receiver_stalls;
    int          hold_cycles;
    int          ready_left;

    rtu_idle_gap_frame_receiver #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // Free-running clock, 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hand out the buffered bytes as one run, or a single empty frame end.
    function automatic void unload_frame(bit is_frame_end);
        t_out r;
        int   k;
        if (bytes_held == 0) begin
            r.out_byte  = 8'h00;
            r.has_data  = 1'b0;
            r.frame_end = is_frame_end;
            r.last      = 1'b1;
            pending_results.push_back(r);
        end else begin
            for (k = 0; k < bytes_held; k++) begin
                r.out_byte  = frame_bytes[k];
                r.has_data  = 1'b1;
                r.frame_end = is_frame_end;
                r.last      = (k + 1 == bytes_held);
                pending_results.push_back(r);
            end
        end
        bytes_held = 0;
    endfunction

    // Advance the framer model by one accepted request.
    function automatic void frame_request(t_in r);
        if (r.req_type == REQ_BYTE) begin
            heard_byte = 1'b1;
            if (store_enable) begin
                if (bytes_held < BUFFER_BYTES) begin
                    frame_bytes[bytes_held] = r.rx_byte;
                    bytes_held++;
                end
                if (bytes_held >= BUFFER_BYTES)
                    unload_frame(1'b0);
            end
        end else if (heard_byte) begin
            heard_byte  = 1'b0;
            quiet_ticks = 16'd0;
        end else if (quiet_ticks < gap_limit) begin
            quiet_ticks = quiet_ticks + 16'd1;
        end else if (quiet_ticks == gap_limit) begin
            quiet_ticks = IDLE_DISARMED;
            unload_frame(1'b1);
        end
    endfunction

    // Receiver side: random stall bursts or steady ready, or a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (!receiver_stalls) begin
            i_out_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if (i_out_ready && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            ready_left = $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
            ready_left = $urandom_range(0, 9);
        end
    end

    // Compare each accepted result with the oldest one owed.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing owed: out_byte %0h has_data %0b frame_end %0b",
                       o_out.out_byte, o_out.has_data, o_out.frame_end);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.out_byte !== want.out_byte) begin
                    $error("out_byte mismatch: expected %0h, actual %0h",
                           want.out_byte, o_out.out_byte);
                    fail_count++;
                end
                if (o_out.has_data !== want.has_data) begin
                    $error("has_data mismatch: expected %0b, actual %0b",
                           want.has_data, o_out.has_data);
                    fail_count++;
                end
                if (o_out.frame_end !== want.frame_end) begin
                    $error("frame_end mismatch: expected %0b, actual %0b",
                           want.frame_end, o_out.frame_end);
                    fail_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.last, o_out.last);
                    fail_count++;
                end
            end
        end
    end

    // Offer one request, possibly after a gap, and return at the edge that accepts it.
    task automatic send_req(logic kind, logic [7:0] data);
        t_in r;
        int  gap;
        r.req_type = kind;
        r.rx_byte  = data;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        frame_request(r);
        requests_sent++;
    endtask

    // Drop the request valid, then wait until every owed result has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; only called while the block is idle.
    task automatic write_regs(logic [15:0] limit, bit enable);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDLE_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RX_ENABLE;
        i_cfg_data <= {15'd0, enable};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        gap_limit    = limit;
        store_enable = enable;
    endtask

    // A frame of random bytes followed by a number of ticks.
    task automatic send_frame(int nbytes, int nticks);
        repeat (nbytes) send_req(REQ_BYTE, 8'($urandom));
        repeat (nticks) send_req(REQ_TICK, 8'($urandom));
    endtask

    // Reset values: bytes are dropped, the gap still ends a frame, disarmed ticks do nothing.
    task automatic test_dropped_bytes_and_empty_end();
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_BYTE, 8'hFF);
        repeat (4) send_req(REQ_TICK, 8'hFF);
        wait_drained();
    endtask

    // A zero limit ends the frame on the second tick after the last byte.
    task automatic test_frame_end_limit_zero();
        write_regs(16'd0, 1'b1);
        send_req(REQ_BYTE, 8'h00);
        send_req(REQ_BYTE, 8'hFF);
        send_req(REQ_BYTE, 8'h5A);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_TICK, 8'hA5);
        send_req(REQ_BYTE, 8'h80);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_TICK, 8'h00);
        wait_drained();
    endtask

    // An all-ones limit matches the disarmed counter; one below it never does.
    task automatic test_limit_extremes();
        write_regs(16'hFFFF, 1'b1);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_TICK, 8'h00);
        wait_drained();
        write_regs(16'hFFFE, 1'b0);
        send_req(REQ_TICK, 8'h00);
        wait_drained();
        write_regs(16'd1, 1'b1);
        send_req(REQ_BYTE, 8'h01);
        repeat (3) send_req(REQ_TICK, 8'h00);
        wait_drained();
    endtask

    // Mostly well-formed frames under random settings, with noise and cut-short gaps.
    task automatic test_random_traffic(int target);
        int   kind;
        int   pick;
        logic [15:0] limit;
        while (requests_sent < target) begin
            wait_drained();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                limit = 16'd0;
            else if (pick == 1)
                limit = 16'd1;
            else
                limit = 16'($urandom_range(2, 4));
            write_regs(limit, $urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 6)) begin
                kind = $urandom_range(0, 15);
                if (kind == 0)
                    repeat ($urandom_range(1, 5))
                        send_req(1'($urandom_range(0, 1)), 8'($urandom));
                else if (kind == 1)
                    send_frame($urandom_range(60, 70), gap_limit + 2);
                else if (kind <= 3)
                    send_frame($urandom_range(1, 8), $urandom_range(1, gap_limit + 1));
                else
                    send_frame($urandom_range(1, 12), gap_limit + 2 + $urandom_range(0, 1));
            end
        end
        wait_drained();
    endtask

    // Hold the receiver off while a full buffer and more bytes are offered.
    task automatic test_output_backpressure();
        wait_drained();
        write_regs(16'd3, 1'b1);
        hold_cycles = 400;
        send_frame(70, 5);
        wait_drained();
    endtask

    // Closing stretch with neither side idling.
    task automatic test_no_idling(int count);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        test_random_traffic(requests_sent + count);
    endtask

    // Safety net for a hung handshake.
    initial begin
        #5ms;
        $display("** rtu_idle_gap_frame_receiver: FAILED **");
        $finish;
    end

    initial begin
        fail_count      = 0;
        requests_sent   = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_cycles     = 0;
        ready_left      = 0;
        bytes_held      = 0;
        quiet_ticks     = IDLE_DISARMED;
        heard_byte      = 1'b0;
        gap_limit       = IDLE_LIMIT_RST;
        store_enable    = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_IDLE_LIMIT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dropped_bytes_and_empty_end();
        test_frame_end_limit_zero();
        test_limit_extremes();
        test_random_traffic(90);
        test_output_backpressure();
        test_no_idling(20);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** rtu_idle_gap_frame_receiver: PASSED **");
        else
            $display("** rtu_idle_gap_frame_receiver: FAILED **");
        $finish;
    end

endmodule

[rtu_idle_gap_frame_receiver.f]
rtl/rtuigfr_pkg.sv
rtl/rtu_idle_gap_frame_receiver.sv
verif/rtu_idle_gap_frame_receiver_tb.sv
